### design/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Types and constants shared by the exponentiation core and its units.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int DEFAULT_WIDTH = 64;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MODULUS  = 1'b1;

    // Status reported by each multi-cycle arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

### design/mexp_reduce.sv
// ----------------------------------------------------------------------------
// Serial modular reduction
// Computes value mod modulus by restoring remainder steps, one bit of the
// value per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module mexp_reduce #(
    parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [WIDTH-1:0]        value,
    input  logic [WIDTH-1:0]        modulus,
    output logic [WIDTH-1:0]        remainder,
    output mexp_pkg::unit_status_t  status
);

    localparam int CNT_W = $clog2(WIDTH);

    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] shift_reg;
    logic [WIDTH-1:0] mod_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [WIDTH:0]   trial;
    logic [WIDTH+1:0] diff;
    logic [WIDTH-1:0] rem_next;

    // The partial remainder stays below twice the modulus, so one
    // compare-and-subtract brings it back into range.
    always_comb
    begin
        trial    = {rem_reg, shift_reg[WIDTH-1]};
        diff     = {1'b0, trial} - {2'b00, mod_reg};
        rem_next = diff[WIDTH+1] ? trial[WIDTH-1:0] : diff[WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            shift_reg <= '0;
            mod_reg   <= '0;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg   <= '0;
                shift_reg <= value;
                mod_reg   <= modulus;
                cnt_reg   <= CNT_W'(WIDTH - 1);
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg   <= rem_next;
                shift_reg <= {shift_reg[WIDTH-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### design/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// Serial modular multiplier
// Forms a * b mod m by shift-and-add over the bits of b, most significant
// first. For each bit it performs a modular doubling, then a conditional
// modular add of a.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
    parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [WIDTH-1:0]        a,
    input  logic [WIDTH-1:0]        b,
    input  logic [WIDTH-1:0]        m,
    output logic [WIDTH-1:0]        product,
    output mexp_pkg::unit_status_t  status
);

    localparam int CNT_W = $clog2(WIDTH);

    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_shift_reg;
    logic [WIDTH-1:0] m_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             phase_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [WIDTH-1:0] addend;
    logic [WIDTH:0]   sum;
    logic [WIDTH+1:0] diff;
    logic [WIDTH-1:0] acc_sum;
    logic             add_en;

    // Both operands are below m, so the sum is below 2m and needs at most
    // one subtraction of m.
    always_comb
    begin
        addend  = phase_reg ? a_reg : acc_reg;
        add_en  = !phase_reg || b_shift_reg[WIDTH-1];
        sum     = {1'b0, acc_reg} + {1'b0, addend};
        diff    = {1'b0, sum} - {2'b00, m_reg};
        acc_sum = diff[WIDTH+1] ? sum[WIDTH-1:0] : diff[WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            a_reg       <= '0;
            b_shift_reg <= '0;
            m_reg       <= '0;
            cnt_reg     <= '0;
            phase_reg   <= 1'b0;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                acc_reg     <= '0;
                a_reg       <= a;
                b_shift_reg <= b;
                m_reg       <= m;
                cnt_reg     <= CNT_W'(WIDTH - 1);
                phase_reg   <= 1'b0;
                busy_reg    <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (add_en)
                begin
                    acc_reg <= acc_sum;
                end
                phase_reg <= !phase_reg;
                if (phase_reg)
                begin
                    b_shift_reg <= {b_shift_reg[WIDTH-2:0], 1'b0};
                    if (cnt_reg == '0)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
            end
        end
    end

    assign product     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### design/modular_exponentiation_core.sv
// ----------------------------------------------------------------------------
// Modular exponentiation core
// Raises each base to the configured exponent modulo the configured modulus
// by right-to-left binary square-and-multiply on bit-serial multipliers.
//
//   Channel   Handshake                    Payload
//   input     in_valid / in_stall          base_value
//   output    out_valid / out_stall        power_result
//   config    write_enable                 reg_index, write_data
//
// Each beat first reduces the base modulo the modulus, one bit per cycle, and
// then, for each exponent bit up to the highest set one, runs the square and
// the multiply side by side on two serial multipliers.
// A new beat is taken once the previous result has moved to the output
// register, which holds it while out_stall is high. There is no clearing pass
// after reset. A zero modulus returns zero without running the reduction.
// ----------------------------------------------------------------------------
module modular_exponentiation_core #(
    parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             write_enable,
    input  logic [mexp_pkg::CFG_INDEX_W-1:0] reg_index,
    input  logic [WIDTH-1:0]                 write_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [WIDTH-1:0]                 base_value,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [WIDTH-1:0]                 power_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_STEP,
        S_WAIT,
        S_EMIT
    } state_t;

    state_t           state_reg;
    logic [WIDTH-1:0] exponent_reg;
    logic [WIDTH-1:0] modulus_reg;
    logic [WIDTH-1:0] exp_left_reg;
    logic [WIDTH-1:0] r_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] out_data_reg;
    logic             out_valid_reg;

    logic             in_accept;
    logic             red_start;
    logic             mul_start;
    logic             out_load;
    logic [WIDTH-1:0] red_rem;
    logic [WIDTH-1:0] mul_product;
    logic [WIDTH-1:0] sq_product;

    mexp_pkg::unit_status_t red_status;
    mexp_pkg::unit_status_t mul_status;
    mexp_pkg::unit_status_t sq_status;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign red_start = in_accept && (modulus_reg != '0);
    assign mul_start = (state_reg == S_STEP) && (exp_left_reg != '0);
    assign out_load  = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= '0;
            modulus_reg  <= WIDTH'(1);
        end
        else if (write_enable)
        begin
            unique case (reg_index)
                mexp_pkg::REG_EXPONENT: exponent_reg <= write_data;
                mexp_pkg::REG_MODULUS:  modulus_reg  <= write_data;
                default:                ;
            endcase
        end
    end

    mexp_reduce #(.WIDTH(WIDTH)) u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (red_start),
        .value     (base_value),
        .modulus   (modulus_reg),
        .remainder (red_rem),
        .status    (red_status)
    );

    // Multiply of the running result and squaring of the base share the
    // same start and finish together.
    mexp_mulmod #(.WIDTH(WIDTH)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (r_reg),
        .b       (b_reg),
        .m       (modulus_reg),
        .product (mul_product),
        .status  (mul_status)
    );

    mexp_mulmod #(.WIDTH(WIDTH)) u_sq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (b_reg),
        .b       (b_reg),
        .m       (modulus_reg),
        .product (sq_product),
        .status  (sq_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            exp_left_reg  <= '0;
            r_reg         <= '0;
            b_reg         <= '0;
            out_data_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        exp_left_reg <= exponent_reg;
                        if (modulus_reg == '0)
                        begin
                            r_reg     <= '0;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_REDUCE;
                        end
                    end
                end
                S_REDUCE:
                begin
                    if (red_status.done)
                    begin
                        b_reg     <= red_rem;
                        // One reduced by the modulus: zero only for a modulus of one.
                        r_reg     <= (modulus_reg == WIDTH'(1)) ? '0 : WIDTH'(1);
                        state_reg <= S_STEP;
                    end
                end
                S_STEP:
                begin
                    if (exp_left_reg == '0)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (sq_status.done && mul_status.done)
                    begin
                        if (exp_left_reg[0])
                        begin
                            r_reg <= mul_product;
                        end
                        b_reg        <= sq_product;
                        exp_left_reg <= exp_left_reg >> 1;
                        state_reg    <= S_STEP;
                    end
                end
                S_EMIT:
                begin
                    if (out_load)
                    begin
                        out_data_reg  <= r_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign power_result = out_data_reg;

endmodule

### design/mexp_checker.sv
// ----------------------------------------------------------------------------
// Modular exponentiation port checker
// Watches the core's ports and checks the ordering of beats over time.
// ----------------------------------------------------------------------------
module mexp_checker #(
    parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [WIDTH-1:0] power_result
);

    // A result waiting at the output holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(power_result))
        else $error("power_result changed while stalled");

    // Once a beat is taken the core is busy with it.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again straight after a beat");

    // A new result only appears from work in progress.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while the core was idle");

    // The core frees its input only once the result has reached the output.
    a_free_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
        else $error("input freed without a result");

endmodule

bind modular_exponentiation_core mexp_checker #(.WIDTH(WIDTH)) u_mexp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .power_result (power_result)
);

### tb/tb.sv
// ----------------------------------------------------------------------------
// Modular exponentiation core testbench
// Drives base values through the core under a series of exponent and modulus
// settings, predicts each power with a double-width square-and-multiply, and
// compares every result beat in order. Both channels idle and stall at
// random, including a long output hold and a full drain part-way through.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = mexp_pkg::DEFAULT_WIDTH;
    localparam int QUIET_LIMIT = 60000;
    localparam int HOLD_CYCLES = 6000;
    localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
    localparam logic [W-1:0] BIG_PRIME = ALL_ONES - 58;

    class pow_scoreboard;
        logic [W-1:0] exp_copy = '0;
        logic [W-1:0] mod_copy = 1;
        logic [W-1:0] expected_powers[$];
        int mismatches = 0;
        int bases_taken = 0;
        int results_seen = 0;

        function void set_exponent(logic [W-1:0] value);
            exp_copy = value;
        endfunction

        function void set_modulus(logic [W-1:0] value);
            mod_copy = value;
        endfunction

        // Right-to-left square-and-multiply, every product kept at double width.
        function logic [W-1:0] mod_power(logic [W-1:0] b, logic [W-1:0] e,
                                         logic [W-1:0] m);
            logic [2*W-1:0] wide_m;
            logic [2*W-1:0] wide_b;
            logic [2*W-1:0] wide_r;
            if (m == 0)
                return '0;
            wide_m = m;
            wide_b = b % m;
            wide_r = 1 % wide_m;
            for (int i = 0; i < W; i++)
            begin
                if (e[i])
                    wide_r = (wide_r * wide_b) % wide_m;
                wide_b = (wide_b * wide_b) % wide_m;
            end
            return wide_r[W-1:0];
        endfunction

        function void note_base(logic [W-1:0] b);
            expected_powers.push_back(mod_power(b, exp_copy, mod_copy));
            bases_taken++;
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(logic [W-1:0] got);
            logic [W-1:0] want;
            results_seen++;
            if (expected_powers.size() == 0)
                report_mismatch($sformatf("power_result %h with no base waiting", got));
            else
            begin
                want = expected_powers.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("power_result %h, expected %h", got, want));
            end
        endtask

        function int pending();
            return expected_powers.size();
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             write_enable = 1'b0;
    logic [mexp_pkg::CFG_INDEX_W-1:0] reg_index = mexp_pkg::REG_EXPONENT;
    logic [W-1:0]                     write_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic [W-1:0]                     base_value = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [W-1:0]                     power_result;

    pow_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int backpressure_cycles = 0;
    int settings_used = 0;

    modular_exponentiation_core #(
        .WIDTH(W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .write_enable(write_enable),
        .reg_index(reg_index),
        .write_data(write_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .base_value(base_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .power_result(power_result)
    );

    always #6 clk = ~clk;

    // Result side: random stalls, or a long hold when one is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Everything only changes at the rising edge, so the falling edge shows
    // exactly what the next rising edge will accept.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(power_result);
            if (in_valid && in_stall)
                backpressure_cycles++;
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || write_enable)
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("Timeout: nothing accepted for %0d cycles", QUIET_LIMIT);
                    $display("tb NOT OK");
                    $finish;
                end
            end
        end
    end

    function automatic logic [W-1:0] rand_word();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[W-1:0];
    endfunction

    function automatic logic [W-1:0] rand_modulus();
        logic [W-1:0] m;
        case ($urandom_range(0, 5))
            0: m = 1;
            1: m = ALL_ONES;
            2: m = rand_word() | (W'(1) << (W - 1));
            3: m = W'($urandom_range(2, 1000));
            4: m = rand_word() >> $urandom_range(1, W - 2);
            default: m = BIG_PRIME;
        endcase
        if (m == 0)
            m = 1;
        return m;
    endfunction

    function automatic logic [W-1:0] pick_base(logic [W-1:0] m);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 1;
            2: return ALL_ONES;
            3: return m - 1;
            4: return m;
            default: return rand_word();
        endcase
    endfunction

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // Both registers are written back to back; the enable drops after the second.
    task automatic set_config(input logic [W-1:0] e, input logic [W-1:0] m);
        write_enable <= 1'b1;
        reg_index <= mexp_pkg::REG_EXPONENT;
        write_data <= e;
        @(posedge clk);
        sb.set_exponent(e);
        reg_index <= mexp_pkg::REG_MODULUS;
        write_data <= m;
        @(posedge clk);
        sb.set_modulus(m);
        write_enable <= 1'b0;
        settings_used++;
    endtask

    task automatic send_base(input logic [W-1:0] b);
        bit took;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        base_value <= b;
        do
        begin
            @(negedge clk);
            took = !in_stall;
            if (took)
                sb.note_base(b);
            @(posedge clk);
        end
        while (!took);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [W-1:0] e;
        logic [W-1:0] m;
        int n_items;
        int e_bits;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle(21, 54);

        // Reset settings: modulus of one with a zero exponent.
        send_base('0);
        send_base(ALL_ONES);
        wait_drained();

        set_config('0, ALL_ONES);
        send_base('0);
        send_base(1);
        send_base(ALL_ONES);
        wait_drained();

        set_config(5, 1);
        send_base(7);
        send_base(ALL_ONES);
        wait_drained();

        set_config(1, ALL_ONES);
        send_base(ALL_ONES);
        send_base(ALL_ONES - 1);
        wait_drained();

        set_config(2, BIG_PRIME);
        send_base(ALL_ONES);
        send_base(BIG_PRIME - 1);
        wait_drained();

        set_config(3, 2);
        send_base('0);
        send_base(1);
        send_base(2);
        send_base(3);
        wait_drained();

        // Full-length exponent: the slowest case.
        set_config(ALL_ONES, BIG_PRIME);
        send_base(2);
        send_base(rand_word());
        wait_drained();

        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase < 4)
                set_idle(21, 54);
            else if (phase < 8)
                set_idle(54, 21);
            else
                set_idle(0, 0);

            // Mostly short exponents keep the run brief; a few use all bits.
            if (phase % 5 == 3)
            begin
                e = rand_word();
                n_items = 2;
            end
            else
            begin
                e_bits = (phase == 1) ? 4 : $urandom_range(1, 12);
                e = rand_word() & (ALL_ONES >> (W - e_bits));
                n_items = 9;
            end
            m = rand_modulus();
            set_config(e, m);

            for (int i = 0; i < n_items; i++)
            begin
                // Hold the result side long enough for the core to fill up.
                if (phase == 1 && i == 1)
                    hold_requests <= hold_requests + 1;
                if (phase == 5 && i == 4)
                    wait_drained();
                send_base(pick_base(m));
            end
            wait_drained();
        end

        repeat (200) @(posedge clk);

        $display("Covered %0d bases under %0d register settings, short and full exponents.",
                 sb.bases_taken, settings_used);
        $display("Saw %0d results, input held back in %0d cycles, %0d mismatches.",
                 sb.results_seen, backpressure_cycles, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
